// ----- hw/rtl/frta_pkg.sv -----
`timescale 1ns / 1ps
// package for the free region table allocator
// shared constants, operation and status codes, controller/datapath structs
package frta_pkg;

  localparam int REGIONS_DEF = 64;
  localparam int PAGE_BITS   = 12;
  localparam int ADDR_W      = 64;
  localparam int PNW         = ADDR_W - PAGE_BITS;
  localparam int RND_W       = 32;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_MARK  = 2'd1;
  localparam logic [1:0] OP_FREE  = 2'd2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD       = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_NO_MEMORY = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam logic [1:0] WS_NONE = 2'd0;
  localparam logic [1:0] WS_A    = 2'd1;
  localparam logic [1:0] WS_B    = 2'd2;
  localparam logic [1:0] WS_C    = 2'd3;

  localparam logic DIV_K   = 1'b0;
  localparam logic DIV_OFF = 1'b1;

  typedef struct packed {
    logic       clr;
    logic       in_load;
    logic       scan_start;
    logic       div_start;
    logic       div_sel;
    logic       k_load;
    logic [1:0] wr_step;
    logic       out_load;
    logic [2:0] sts;
  } frta_cmd_t;

  typedef struct packed {
    logic       clr_last;
    logic [1:0] op;
    logic       op_bad;
    logic       scan_busy;
    logic       div_busy;
    logic       cnt_zero;
    logic       cont_found;
    logic       mark_full;
    logic       free_full;
  } frta_sts_t;

endpackage

// ----- hw/rtl/free_region_table_allocator_unit.sv -----
`timescale 1ns / 1ps
// Free region table allocator: keeps free page ranges, splits, merges, picks.
// One transaction in gives one transaction out (status, alloc_addr).
// Both channels use valid/stall; a transaction moves when valid is high and
// stall is low. Reset is synchronous, active low on rst_n.
// After reset the table is cleared by a pass that writes one slot a cycle;
// in_stall stays high during that pass.
// Items are processed one at a time. A rejected item (bad alignment, bad op)
// is answered without a table scan. Mark used and free take one table scan
// through the single memory read port. Random allocate takes two scans and two
// remainder passes, or one scan when no range fits.
// The result sits in an output register; the next item is accepted while it
// waits. If out_stall is held, the next item finishes and waits in the
// controller until the output register is taken.
// depends on frta_pkg, frta_ctrl, frta_dp
module free_region_table_allocator_unit import frta_pkg::*; #(
  parameter int REGIONS = REGIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_first_addr,
  input  logic [ADDR_W-1:0] in_end_addr,
  input  logic [ADDR_W-1:0] in_size_bytes,
  input  logic [RND_W-1:0]  in_random_a,
  input  logic [RND_W-1:0]  in_random_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_alloc_addr
);

  frta_cmd_t cmd;
  frta_sts_t dsts;

  frta_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dsts),
    .cmd       (cmd)
  );

  frta_dp #(.REGIONS(REGIONS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_op          (in_op),
    .in_first_addr  (in_first_addr),
    .in_end_addr    (in_end_addr),
    .in_size_bytes  (in_size_bytes),
    .in_random_a    (in_random_a),
    .in_random_b    (in_random_b),
    .cmd            (cmd),
    .sts            (dsts),
    .out_status     (out_status),
    .out_alloc_addr (out_alloc_addr)
  );

`ifndef SYNTHESIS
  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_alloc_addr == '0))
    else $error("nonzero address with error status");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_start |-> !dsts.div_busy)
    else $error("remainder unit restarted while busy");

  a_wr_no_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_step != WS_NONE) |-> !dsts.scan_busy)
    else $error("table write during scan");
`endif

endmodule

// ----- hw/rtl/frta_divu.sv -----
`timescale 1ns / 1ps
// iterative remainder unit, one dividend bit per cycle
// depends on frta_pkg
module frta_divu import frta_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RND_W-1:0] dividend,
  input  logic [PNW:0]     divisor,
  output logic             busy,
  output logic [RND_W-1:0] rem
);

  localparam int CW = $clog2(RND_W + 1);

  logic             run_r;
  logic [CW-1:0]    cnt_r;
  logic [RND_W-1:0] dvd_r;
  logic [RND_W-1:0] rem_r;
  logic [PNW:0]     dsr_r;
  logic [PNW:0]     t;
  logic [PNW:0]     diff;
  logic [RND_W-1:0] rem_nxt;

  always_comb begin
    t = (PNW + 1)'({rem_r, dvd_r[RND_W-1]});
    diff = t - dsr_r;
    rem_nxt = (t >= dsr_r) ? diff[RND_W-1:0] : t[RND_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= CW'(RND_W);
    end else if (run_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == CW'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (run_r) begin
      dvd_r <= {dvd_r[RND_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign busy = run_r;
  assign rem  = rem_r;

endmodule

// ----- hw/rtl/frta_dp.sv -----
`timescale 1ns / 1ps
// datapath: region table memory, scan trackers, remainder unit, result register
// depends on frta_pkg and frta_divu
module frta_dp import frta_pkg::*; #(
  parameter int REGIONS = REGIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_first_addr,
  input  logic [ADDR_W-1:0] in_end_addr,
  input  logic [ADDR_W-1:0] in_size_bytes,
  input  logic [RND_W-1:0]  in_random_a,
  input  logic [RND_W-1:0]  in_random_b,
  input  frta_cmd_t         cmd,
  output frta_sts_t         sts,
  output logic [2:0]        out_status,
  output logic [ADDR_W-1:0] out_alloc_addr
);

  localparam int IDXW = $clog2(REGIONS);
  localparam int CNTW = $clog2(REGIONS + 1);
  localparam int EW   = 2 * PNW + 1;

  logic [EW-1:0] mem_r [REGIONS];

  logic [1:0]        op_r;
  logic [ADDR_W-1:0] fa_r, ea_r, size_r;
  logic [RND_W-1:0]  ra_r, rb_r;

  logic [IDXW-1:0] clr_idx_r;
  logic            scan_on_r;
  logic [IDXW-1:0] scan_addr_r;
  logic            rd_vld_r;
  logic [IDXW-1:0] rd_idx_r;
  logic [EW-1:0]   rdata_r;

  logic [CNTW-1:0] cnt_r, k_r;
  logic            sel_found_r;
  logic [PNW-1:0]  sel_first_r, sel_len_r;
  logic            cont_found_r;
  logic [IDXW-1:0] cont_idx_r;
  logic [PNW-1:0]  cf_r, ce_r;
  logic [1:0]      fcnt_r;
  logic [IDXW-1:0] free0_r, free1_r;
  logic            left_found_r;
  logic [IDXW-1:0] left_idx_r;
  logic [PNW-1:0]  left_first_r;
  logic            r0_found_r, r1_found_r;
  logic [IDXW-1:0] r0_idx_r, r1_idx_r;
  logic [PNW-1:0]  r0_end_r, r1_end_r;

  logic [2:0]        out_status_r;
  logic [ADDR_W-1:0] out_addr_r;

  logic [PNW-1:0]  b_pg, e_pg, need;
  logic            ev;
  logic [PNW-1:0]  ef, ee, elen;
  logic            fit;
  logic            need_l, need_r;
  logic [1:0]      adds;
  logic            right_found;
  logic [IDXW-1:0] right_idx;
  logic [PNW-1:0]  right_end;
  logic [PNW-1:0]  mb, me;
  logic [IDXW-1:0] tgt;
  logic            tgt_v;
  logic            we;
  logic [IDXW-1:0] waddr;
  logic [EW-1:0]   wdata;
  logic [RND_W-1:0] div_dvd;
  logic [PNW:0]     div_dsr;
  logic             div_busy;
  logic [RND_W-1:0] div_rem;
  logic             op_bad;

  assign b_pg = fa_r[ADDR_W-1:PAGE_BITS];
  assign e_pg = ea_r[ADDR_W-1:PAGE_BITS];
  assign need = size_r[ADDR_W-1:PAGE_BITS];
  assign ev   = rdata_r[EW-1];
  assign ef   = rdata_r[2*PNW-1:PNW];
  assign ee   = rdata_r[PNW-1:0];
  assign elen = ee - ef;
  assign fit  = ev && (elen >= need);

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_r   <= in_op;
      fa_r   <= in_first_addr;
      ea_r   <= in_end_addr;
      size_r <= in_size_bytes;
      ra_r   <= in_random_a;
      rb_r   <= in_random_b;
    end
  end

  always_comb begin
    case (op_r) inside
      OP_ALLOC: op_bad = (size_r[PAGE_BITS-1:0] != '0);
      OP_MARK, OP_FREE: op_bad = (fa_r[PAGE_BITS-1:0] != '0) ||
                                 (ea_r[PAGE_BITS-1:0] != '0) || (fa_r > ea_r);
      default: op_bad = 1'b1;
    endcase
  end

  // table clear after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r <= '0;
    end else if (cmd.clr) begin
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  // scan read pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_on_r   <= 1'b0;
      scan_addr_r <= '0;
      rd_vld_r    <= 1'b0;
    end else begin
      rd_vld_r <= scan_on_r;
      if (cmd.scan_start) begin
        scan_on_r   <= 1'b1;
        scan_addr_r <= '0;
      end else if (scan_on_r) begin
        scan_addr_r <= scan_addr_r + 1'b1;
        if (scan_addr_r == IDXW'(REGIONS - 1)) begin
          scan_on_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r  <= mem_r[scan_addr_r];
    rd_idx_r <= scan_addr_r;
  end

  // trackers
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      cnt_r        <= '0;
      sel_found_r  <= 1'b0;
      cont_found_r <= 1'b0;
      fcnt_r       <= '0;
      left_found_r <= 1'b0;
      r0_found_r   <= 1'b0;
      r1_found_r   <= 1'b0;
    end else if (rd_vld_r) begin
      if (fit) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (fit && !sel_found_r) begin
        if (k_r == '0) begin
          sel_found_r <= 1'b1;
          sel_first_r <= ef;
          sel_len_r   <= elen;
        end else begin
          k_r <= k_r - 1'b1;
        end
      end
      if (ev && (b_pg >= ef) && (e_pg <= ee) && !cont_found_r) begin
        cont_found_r <= 1'b1;
        cont_idx_r   <= rd_idx_r;
        cf_r         <= ef;
        ce_r         <= ee;
      end
      if (!ev) begin
        if (fcnt_r == 2'd0) begin
          free0_r <= rd_idx_r;
        end else if (fcnt_r == 2'd1) begin
          free1_r <= rd_idx_r;
        end
        if (fcnt_r != 2'd2) begin
          fcnt_r <= fcnt_r + 1'b1;
        end
      end
      if (ev && (ee == b_pg) && !left_found_r) begin
        left_found_r <= 1'b1;
        left_idx_r   <= rd_idx_r;
        left_first_r <= ef;
      end
      if (ev && (ef == e_pg)) begin
        if (!r0_found_r) begin
          r0_found_r <= 1'b1;
          r0_idx_r   <= rd_idx_r;
          r0_end_r   <= ee;
        end else if (!r1_found_r) begin
          r1_found_r <= 1'b1;
          r1_idx_r   <= rd_idx_r;
          r1_end_r   <= ee;
        end
      end
    end
    if (cmd.k_load) begin
      k_r <= div_rem[CNTW-1:0];
    end
  end

  // split and merge decisions
  always_comb begin
    need_l = b_pg > cf_r;
    need_r = e_pg < ce_r;
    adds   = {1'b0, need_l} + {1'b0, need_r};
    if (r0_found_r && !(left_found_r && (r0_idx_r == left_idx_r))) begin
      right_found = 1'b1;
      right_idx   = r0_idx_r;
      right_end   = r0_end_r;
    end else begin
      right_found = r0_found_r && r1_found_r;
      right_idx   = r1_idx_r;
      right_end   = r1_end_r;
    end
    mb = left_found_r ? left_first_r : b_pg;
    me = right_found ? right_end : e_pg;
    tgt   = free0_r;
    tgt_v = (fcnt_r != 2'd0);
    if (left_found_r && (!tgt_v || (left_idx_r < tgt))) begin
      tgt = left_idx_r;
    end
    tgt_v = tgt_v || left_found_r;
    if (right_found && (!tgt_v || (right_idx < tgt))) begin
      tgt = right_idx;
    end
  end

  // write port
  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_idx_r;
      if (clr_idx_r == '0) begin
        wdata = {1'b1, PNW'(1), {PNW{1'b1}}};
      end
    end else if (op_r == OP_MARK) begin
      case (cmd.wr_step)
        WS_A: begin
          we    = need_l;
          waddr = free0_r;
          wdata = {1'b1, cf_r, b_pg};
        end
        WS_B: begin
          we    = need_r;
          waddr = need_l ? free1_r : free0_r;
          wdata = {1'b1, e_pg, ce_r};
        end
        WS_C: begin
          we    = 1'b1;
          waddr = cont_idx_r;
        end
        default: we = 1'b0;
      endcase
    end else if (op_r == OP_FREE) begin
      case (cmd.wr_step)
        WS_A: begin
          we    = left_found_r;
          waddr = left_idx_r;
        end
        WS_B: begin
          we    = right_found;
          waddr = right_idx;
        end
        WS_C: begin
          we    = 1'b1;
          waddr = tgt;
          wdata = {1'b1, mb, me};
        end
        default: we = 1'b0;
      endcase
    end
  end

  assign div_dvd = (cmd.div_sel == DIV_K) ? ra_r : rb_r;
  assign div_dsr = (cmd.div_sel == DIV_K) ? (PNW + 1)'(cnt_r)
                                          : ({1'b0, sel_len_r} - {1'b0, need} + 1'b1);

  frta_divu u_divu (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .busy     (div_busy),
    .rem      (div_rem)
  );

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= cmd.sts;
      if ((op_r == OP_ALLOC) && (cmd.sts == ST_OK)) begin
        out_addr_r <= {sel_first_r + PNW'(div_rem), {PAGE_BITS{1'b0}}};
      end else begin
        out_addr_r <= '0;
      end
    end
  end

  assign out_status     = out_status_r;
  assign out_alloc_addr = out_addr_r;

  assign sts.clr_last   = (clr_idx_r == IDXW'(REGIONS - 1));
  assign sts.op         = op_r;
  assign sts.op_bad     = op_bad;
  assign sts.scan_busy  = scan_on_r | rd_vld_r;
  assign sts.div_busy   = div_busy;
  assign sts.cnt_zero   = (cnt_r == '0);
  assign sts.cont_found = cont_found_r;
  assign sts.mark_full  = ({1'b0, fcnt_r} < {1'b0, adds});
  assign sts.free_full  = !left_found_r && !right_found && (fcnt_r == 2'd0);

endmodule

// ----- hw/rtl/frta_ctrl.sv -----
`timescale 1ns / 1ps
// controller state machine: sequences clear, scans, remainders and table writes
// depends on frta_pkg
module frta_ctrl import frta_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  logic      out_stall,
  input  frta_sts_t sts,
  output frta_cmd_t cmd
);

  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_DEC  = 4'd2;
  localparam logic [3:0] S_SCAN = 4'd3;
  localparam logic [3:0] S_DIV  = 4'd4;
  localparam logic [3:0] S_WRA  = 4'd5;
  localparam logic [3:0] S_WRB  = 4'd6;
  localparam logic [3:0] S_WRC  = 4'd7;
  localparam logic [3:0] S_FIN  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       pass_r, pass_nxt;
  logic [2:0] sts_r, sts_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    pass_nxt      = pass_r;
    sts_nxt       = sts_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.sts       = sts_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.op_bad) begin
          sts_nxt   = ST_BAD;
          state_nxt = S_FIN;
        end else begin
          cmd.scan_start = 1'b1;
          pass_nxt       = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_busy) begin
          case (sts.op)
            OP_ALLOC: begin
              if (pass_r) begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_OFF;
                state_nxt     = S_DIV;
              end else if (sts.cnt_zero) begin
                sts_nxt   = ST_NO_MEMORY;
                state_nxt = S_FIN;
              end else begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = DIV_K;
                state_nxt     = S_DIV;
              end
            end
            OP_MARK: begin
              if (!sts.cont_found) begin
                sts_nxt   = ST_NOT_FOUND;
                state_nxt = S_FIN;
              end else if (sts.mark_full) begin
                sts_nxt   = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_WRA;
              end
            end
            OP_FREE: begin
              if (sts.free_full) begin
                sts_nxt   = ST_FULL;
                state_nxt = S_FIN;
              end else begin
                state_nxt = S_WRA;
              end
            end
            default: begin
              sts_nxt   = ST_BAD;
              state_nxt = S_FIN;
            end
          endcase
        end
      end
      S_DIV: begin
        cmd.div_sel = pass_r ? DIV_OFF : DIV_K;
        if (!sts.div_busy) begin
          if (pass_r) begin
            sts_nxt   = ST_OK;
            state_nxt = S_FIN;
          end else begin
            cmd.k_load     = 1'b1;
            cmd.scan_start = 1'b1;
            pass_nxt       = 1'b1;
            state_nxt      = S_SCAN;
          end
        end
      end
      S_WRA: begin
        cmd.wr_step = WS_A;
        state_nxt   = S_WRB;
      end
      S_WRB: begin
        cmd.wr_step = WS_B;
        state_nxt   = S_WRC;
      end
      S_WRC: begin
        cmd.wr_step = WS_C;
        sts_nxt     = ST_OK;
        state_nxt   = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      pass_r      <= 1'b0;
      sts_r       <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pass_r      <= pass_nxt;
      sts_r       <= sts_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- tb/frta_checker.sv -----
`timescale 1ns / 1ps
// checker for the free region table allocator: watches both channels, keeps a
// copy of the free range table, predicts status and address, compares them
// depends on frta_pkg
module frta_checker import frta_pkg::*; #(
  parameter int REGIONS = REGIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        in_op,
  input  logic [ADDR_W-1:0] in_first_addr,
  input  logic [ADDR_W-1:0] in_end_addr,
  input  logic [ADDR_W-1:0] in_size_bytes,
  input  logic [RND_W-1:0]  in_random_a,
  input  logic [RND_W-1:0]  in_random_b,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [2:0]        out_status,
  input  logic [ADDR_W-1:0] out_alloc_addr,
  output int                fail_count,
  output int                pending,
  output int                ok_count,
  output int                full_count
);

  typedef struct packed {
    logic [2:0]        status;
    logic [ADDR_W-1:0] addr;
  } alloc_result_t;

  logic           live [REGIONS];
  logic [PNW-1:0] lo_pg [REGIONS];
  logic [PNW-1:0] hi_pg [REGIONS];
  alloc_result_t  expected_q[$];

  function automatic int first_empty();
    for (int i = 0; i < REGIONS; i++) if (!live[i]) return i;
    return -1;
  endfunction

  function automatic int empty_slots();
    int n;
    n = 0;
    for (int i = 0; i < REGIONS; i++) if (!live[i]) n++;
    return n;
  endfunction

  function automatic void store_range(logic [PNW-1:0] f, logic [PNW-1:0] e);
    int s;
    s = first_empty();
    if (s >= 0) begin
      live[s] = 1'b1;
      lo_pg[s] = f;
      hi_pg[s] = e;
    end
  endfunction

  function automatic alloc_result_t pick_place(logic [ADDR_W-1:0] sz, logic [63:0] ra,
                                               logic [63:0] rb);
    alloc_result_t r;
    logic [63:0] need, cnt, k, slots, off;
    r = '0;
    if (sz[PAGE_BITS-1:0] != 0) begin
      r.status = ST_BAD;
      return r;
    end
    need = sz >> PAGE_BITS;
    cnt = 0;
    for (int i = 0; i < REGIONS; i++)
      if (live[i] && 64'(hi_pg[i] - lo_pg[i]) >= need) cnt++;
    if (cnt == 0) begin
      r.status = ST_NO_MEMORY;
      return r;
    end
    k = ra % cnt;
    for (int i = 0; i < REGIONS; i++) begin
      if (live[i] && 64'(hi_pg[i] - lo_pg[i]) >= need) begin
        if (k == 0) begin
          slots = 64'(hi_pg[i] - lo_pg[i]) - need + 1;
          off = (slots > 1) ? rb % slots : 0;
          r.status = ST_OK;
          r.addr = {PNW'(64'(lo_pg[i]) + off), {PAGE_BITS{1'b0}}};
          return r;
        end
        k--;
      end
    end
    r.status = ST_NO_MEMORY;
    return r;
  endfunction

  function automatic logic [2:0] carve_range(logic [63:0] b, logic [63:0] e);
    int c, adds;
    logic [PNW-1:0] cf, ce;
    c = -1;
    adds = 0;
    for (int i = 0; i < REGIONS; i++)
      if (c < 0 && live[i] && b >= 64'(lo_pg[i]) && e <= 64'(hi_pg[i])) c = i;
    if (c < 0) return ST_NOT_FOUND;
    cf = lo_pg[c];
    ce = hi_pg[c];
    if (b > 64'(cf)) adds++;
    if (e < 64'(ce)) adds++;
    if (empty_slots() < adds) return ST_FULL;
    if (b > 64'(cf)) store_range(cf, PNW'(b));
    if (e < 64'(ce)) store_range(PNW'(e), ce);
    live[c] = 1'b0;
    return ST_OK;
  endfunction

  function automatic logic [2:0] release_range(logic [63:0] b, logic [63:0] e);
    int lft, rgt;
    lft = -1;
    rgt = -1;
    for (int i = 0; i < REGIONS; i++)
      if (lft < 0 && live[i] && 64'(hi_pg[i]) == b) lft = i;
    for (int i = 0; i < REGIONS; i++)
      if (rgt < 0 && i != lft && live[i] && 64'(lo_pg[i]) == e) rgt = i;
    if (lft < 0 && rgt < 0 && first_empty() < 0) return ST_FULL;
    if (lft >= 0) begin
      b = 64'(lo_pg[lft]);
      live[lft] = 1'b0;
    end
    if (rgt >= 0) begin
      e = 64'(hi_pg[rgt]);
      live[rgt] = 1'b0;
    end
    store_range(PNW'(b), PNW'(e));
    return ST_OK;
  endfunction

  function automatic alloc_result_t apply_request(logic [1:0] op, logic [63:0] fa,
      logic [63:0] ea, logic [63:0] sz, logic [63:0] ra, logic [63:0] rb);
    alloc_result_t r;
    r = '0;
    if (op == OP_ALLOC) r = pick_place(sz, ra, rb);
    else if (op == OP_MARK || op == OP_FREE) begin
      if (fa[PAGE_BITS-1:0] != 0 || ea[PAGE_BITS-1:0] != 0 || fa > ea) r.status = ST_BAD;
      else if (op == OP_MARK) r.status = carve_range(fa >> PAGE_BITS, ea >> PAGE_BITS);
      else r.status = release_range(fa >> PAGE_BITS, ea >> PAGE_BITS);
    end else r.status = ST_BAD;
    if (r.status != ST_OK) r.addr = '0;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alloc_result_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < REGIONS; i++) begin
        live[i] = 1'b0;
        lo_pg[i] = '0;
        hi_pg[i] = '0;
      end
      live[0] = 1'b1;
      lo_pg[0] = PNW'(1);
      hi_pg[0] = '1;
      expected_q.delete();
      fail_count = 0;
      ok_count = 0;
      full_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected transaction status %0d addr %h", $time, out_status,
                   out_alloc_addr);
        end else begin
          exp_r = expected_q.pop_front();
          if (out_status !== exp_r.status) begin
            fail_count++;
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          end
          if (out_alloc_addr !== exp_r.addr) begin
            fail_count++;
            $display("%0t: alloc_addr expected %h actual %h", $time, exp_r.addr,
                     out_alloc_addr);
          end
        end
      end
      if (in_valid && !in_stall) begin
        exp_r = apply_request(in_op, in_first_addr, in_end_addr, in_size_bytes,
                              64'(in_random_a), 64'(in_random_b));
        if (exp_r.status == ST_OK) ok_count++;
        if (exp_r.status == ST_FULL) full_count++;
        expected_q.push_back(exp_r);
      end
    end
  end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// top of the free region table allocator testbench: clock, reset, stimulus
// and verdict; depends on frta_pkg, frta_checker and the allocator unit
module testbench;
  import frta_pkg::*;

  localparam int REGIONS = REGIONS_DEF;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        in_op = OP_ALLOC;
  logic [ADDR_W-1:0] in_first_addr = '0;
  logic [ADDR_W-1:0] in_end_addr = '0;
  logic [ADDR_W-1:0] in_size_bytes = '0;
  logic [RND_W-1:0]  in_random_a = '0;
  logic [RND_W-1:0]  in_random_b = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [2:0]        out_status;
  logic [ADDR_W-1:0] out_alloc_addr;
  int                fail_count, pending, ok_count, full_count;
  int                sent = 0;
  logic              long_hold = 1'b0;
  logic              stim_done = 1'b0;
  logic [63:0]       recent_addr [8];

  always #10 clk = ~clk;

  free_region_table_allocator_unit #(.REGIONS(REGIONS)) DUT (.*);

  frta_checker #(.REGIONS(REGIONS)) u_checker (.*);

  // receiver stall pattern, with one long hold-off that backs up the sender
  always @(negedge clk) begin
    if (long_hold) out_stall <= 1'b1;
    else if (sent < 300 || (sent > 900 && sent < 1100)) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(0, 3) == 0);
  end

  initial begin
    wait (sent == 500);
    long_hold = 1'b1;
    repeat (3000) @(posedge clk);
    long_hold = 1'b0;
  end

  task automatic send(logic [1:0] op, logic [63:0] fa, logic [63:0] ea, logic [63:0] sz,
                      logic [31:0] ra, logic [31:0] rb);
    in_valid <= 1'b1;
    in_op <= op;
    in_first_addr <= fa;
    in_end_addr <= ea;
    in_size_bytes <= sz;
    in_random_a <= ra;
    in_random_b <= rb;
    do @(posedge clk); while (in_stall);
    sent++;
    @(negedge clk);
  endtask

  task automatic idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom, $urandom};
  endfunction

  // mostly page aligned addresses, clustered so frees and marks hit real edges
  function automatic logic [63:0] some_addr();
    case ($urandom_range(0, 5))
      0: return rnd64();
      1: return {rnd64()} & ~64'hFFF;
      2: return recent_addr[$urandom_range(0, 7)];
      default: return 64'({$urandom_range(1, 600)}) << PAGE_BITS;
    endcase
  endfunction

  initial begin
    logic [63:0] a, b, t;
    logic [1:0]  op;
    int          burst;
    for (int i = 0; i < 8; i++) recent_addr[i] = 64'(i + 1) << PAGE_BITS;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // directed corners
    send(OP_ALLOC, 0, 0, 0, '1, '1);
    send(OP_ALLOC, 0, 0, 64'hFFFF_FFFF_FFFF_F000, 0, 0);
    send(OP_ALLOC, 0, 0, '1, 0, 0);
    send(OP_ALLOC, 0, 0, 64'h1000, 32'h5555_5555, 32'hAAAA_AAAA);
    send(OP_UNUSED, '1, '1, '1, '1, '1);
    send(OP_MARK, 64'h1001, 64'h2000, 0, 0, 0);
    send(OP_MARK, 64'h3000, 64'h2000, 0, 0, 0);
    send(OP_MARK, 0, 64'h1000, 0, 0, 0);
    send(OP_MARK, 64'h1000, 64'h1000, 0, 0, 0);
    send(OP_MARK, 64'h5000, 64'h8000, 0, 0, 0);
    send(OP_MARK, 64'h1000, 64'h2000, 0, 0, 0);
    send(OP_MARK, 64'hFFFF_FFFF_FFFF_E000, 64'hFFFF_FFFF_FFFF_F000, 0, 0, 0);
    send(OP_ALLOC, 0, 0, 64'h3000, 32'h1, 32'h7);
    send(OP_FREE, 64'h5000, 64'h6000, 0, 0, 0);
    send(OP_FREE, 64'h7000, 64'h8000, 0, 0, 0);
    send(OP_FREE, 64'h6000, 64'h7000, 0, 0, 0);
    send(OP_FREE, 64'h1000, 64'h2000, 0, 0, 0);
    send(OP_FREE, 64'h9_0000_0000, 64'h9_0000_0000, 0, 0, 0);
    send(OP_FREE, 64'hFFFF_FFFF_FFFF_F000, 64'hFFFF_FFFF_FFFF_F000, 0, 0, 0);
    send(OP_FREE, 64'h0, 64'hFFFF_FFFF_FFFF_F000, 0, 0, 0);
    // fill the table with single page holes to reach the full case
    for (int i = 0; i < REGIONS + 4; i++)
      send(OP_MARK, 64'(2 * i + 700) << PAGE_BITS, 64'(2 * i + 701) << PAGE_BITS, 0, 0, 0);
    send(OP_FREE, 64'h7_0000_0000, 64'h7_0000_1000, 0, 0, 0);
    for (int i = 0; i < REGIONS + 4; i++)
      send(OP_FREE, 64'(2 * i + 700) << PAGE_BITS, 64'(2 * i + 701) << PAGE_BITS, 0, 0, 0);
    // random traffic in bursts
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 20);
      for (int j = 0; j < burst; j++) begin
        a = some_addr();
        b = some_addr();
        if ($urandom_range(0, 9) != 0 && a > b) begin
          t = a;
          a = b;
          b = t;
        end
        if ($urandom_range(0, 3) == 0) b = a + (64'($urandom_range(1, 4)) << PAGE_BITS);
        recent_addr[$urandom_range(0, 7)] = a;
        recent_addr[$urandom_range(0, 7)] = b;
        case ($urandom_range(0, 19))
          0: op = OP_UNUSED;
          1, 2, 3, 4, 5: op = OP_ALLOC;
          6, 7, 8, 9, 10, 11: op = OP_MARK;
          default: op = OP_FREE;
        endcase
        t = ($urandom_range(0, 7) == 0) ? rnd64() :
            64'($urandom_range(0, 64)) << PAGE_BITS;
        send(op, a, b, t, $urandom, $urandom);
      end
      if ($urandom_range(0, 2) != 0) idle($urandom_range(1, 40));
    end
    in_valid <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (pending != 0) @(posedge clk);
    repeat (4 * REGIONS + 200) @(posedge clk);
    $display("ran %0d transactions: %0d accepted with ok, %0d hit a full table", sent,
             ok_count, full_count);
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #40_000_000;
    $display("timeout with %0d transactions outstanding", pending);
    $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- free_region_table_allocator_unit.f -----
hw/rtl/frta_pkg.sv
hw/rtl/frta_divu.sv
hw/rtl/frta_dp.sv
hw/rtl/frta_ctrl.sv
hw/rtl/free_region_table_allocator_unit.sv
tb/frta_checker.sv
tb/testbench.sv
